[design/i64alu_pkg.sv]
// ----------------------------------------------------------------------------
// i64alu_pkg: shared types and constants
// Operation codes, port width and the control word that travels with each
// operation through the ALU pipeline.
// ----------------------------------------------------------------------------
package i64alu_pkg;

	localparam int DATA_WIDTH_DEF = 64;
	localparam int SAFE_BITS_DEF  = 53;

	localparam logic [3:0] FN_AND = 4'd0;
	localparam logic [3:0] FN_OR  = 4'd1;
	localparam logic [3:0] FN_XOR = 4'd2;
	localparam logic [3:0] FN_NOT = 4'd3;
	localparam logic [3:0] FN_SHL = 4'd4;
	localparam logic [3:0] FN_SHR = 4'd5;
	localparam logic [3:0] FN_SAR = 4'd6;
	localparam logic [3:0] FN_ADD = 4'd7;
	localparam logic [3:0] FN_SUB = 4'd8;
	localparam logic [3:0] FN_MUL = 4'd9;
	localparam logic [3:0] FN_DIV = 4'd10;
	localparam logic [3:0] FN_MOD = 4'd11;
	localparam logic [3:0] FN_NEG = 4'd12;
	localparam logic [3:0] FN_EQ  = 4'd13;
	localparam logic [3:0] FN_LT  = 4'd14;
	localparam logic [3:0] FN_LE  = 4'd15;

	typedef struct packed {
		logic       vld;
		logic [3:0] func;
		logic       qneg;   // quotient must be negated
		logic       rneg;   // dividend is negative
		logic       bzero;  // divisor is zero
		logic       azero;  // dividend is zero
	} ctl_t;

endpackage

[design/i64alu_if.sv]
// ----------------------------------------------------------------------------
// i64alu_req_if / i64alu_rsp_if: operation and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface i64alu_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         func;
	logic signed [63:0] operand_a;
	logic signed [63:0] operand_b;

	modport source (output valid, output func, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input func, input operand_a, input operand_b,
		output ready);
endinterface

interface i64alu_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result_value;
	logic               fits_53_bits;

	modport source (output valid, output result_value, output fits_53_bits,
		input ready);
	modport sink (input valid, input result_value, input fits_53_bits,
		output ready);
endinterface

[design/int64_alu_safe_div.sv]
// ----------------------------------------------------------------------------
// int64_alu_safe_div: pipelined 64-bit two's complement ALU
// Logic, shift, add, multiply, divide, modulo and compare with a flag that
// tells whether the result's magnitude fits in SAFE_BITS bits.
// ----------------------------------------------------------------------------
// The ALU takes one operation per cycle while the result side keeps up
// and returns one result per operation, in order. The depth is set by
// the restoring divider, which resolves one
// quotient bit per pipeline stage; every operation, divide or not, walks the
// same stages so results never overtake each other. Two stages in front form
// operand magnitudes, the simple operations and a split multiply (three narrow
// partial products, summed in the second stage); two stages behind apply the
// quotient and remainder signs, the divide-by-zero rules and the range flag.
// When the result channel stalls, the whole pipeline holds and the request
// channel drops ready, so nothing is lost or repeated. Division truncates
// toward zero; divide by zero gives the largest value for a positive
// dividend, the smallest for a negative one and 1 for zero; modulo by zero
// gives 0; the most negative value divided by -1 wraps. Shift amounts are
// unsigned, and 64 or more shift everything out (sign fill for arithmetic
// right shift). Compares return 1 or 0.
module int64_alu_safe_div import i64alu_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int SAFE_BITS  = SAFE_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	i64alu_req_if.sink   req,
	i64alu_rsp_if.source rsp
);

	// The pipeline advances whenever the output register is empty or its
	// transfer completes in this cycle.
	logic adv;

	ctl_t                  ctl_p, ctl_d;
	logic [DATA_WIDTH-1:0] alt_p, ma_p, mb_p, alt_d, quo_d, rem_d;

	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	i64alu_prep #(.W(DATA_WIDTH)) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (req.valid),
		.func   (req.func),
		.a_raw  (req.operand_a),
		.b_raw  (req.operand_b),
		.ctl_s2 (ctl_p),
		.alt_s2 (alt_p),
		.ma_s2  (ma_p),
		.mb_s2  (mb_p)
	);

	i64alu_div #(.W(DATA_WIDTH)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_p),
		.alt_in  (alt_p),
		.ma      (ma_p),
		.mb      (mb_p),
		.ctl_out (ctl_d),
		.alt_out (alt_d),
		.quo     (quo_d),
		.rem     (rem_d)
	);

	i64alu_post #(.W(DATA_WIDTH), .SAFE_BITS(SAFE_BITS)) u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl     (ctl_d),
		.alt     (alt_d),
		.quo     (quo_d),
		.rem     (rem_d),
		.vld_s2  (rsp.valid),
		.res_s2  (rsp.result_value),
		.fits_s2 (rsp.fits_53_bits)
	);

	// A stalled result stays presented.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid)
		else $error("result dropped while stalled");

	// A stall freezes the front of the pipeline.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_p.vld))
		else $error("pipeline moved during stall");

	// Zero always fits, so a cleared range flag implies a nonzero result.
	a_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.fits_53_bits |-> rsp.result_value != 64'sd0)
		else $error("range flag inconsistent with result");

endmodule

[design/i64alu_prep.sv]
// ----------------------------------------------------------------------------
// i64alu_prep: operand preparation, simple operations and multiply
// Stage 1 forms magnitudes, flags, the simple results and the partial
// products; stage 2 sums the products and merges them into one value.
// ----------------------------------------------------------------------------
module i64alu_prep import i64alu_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_vld,
	input  logic [3:0]   func,
	input  logic [63:0]  a_raw,
	input  logic [63:0]  b_raw,
	output ctl_t         ctl_s2,
	output logic [W-1:0] alt_s2,
	output logic [W-1:0] ma_s2,
	output logic [W-1:0] mb_s2
);

	localparam int H  = (W + 1) / 2;
	localparam int L2 = W - H;
	localparam int SW = $clog2(W);

	logic [W-1:0] a, b, na_v, nb_v, simple;
	logic         na, nb, big;
	logic [SW-1:0] sh;

	ctl_t           ctl_s1;
	logic [W-1:0]   alt_s1, ma_s1, mb_s1;
	logic [2*H-1:0] p0_s1;
	logic [L2-1:0]  p1_s1, p2_s1;
	logic [W-1:0]   mul_sum;

	assign a    = a_raw[W-1:0];
	assign b    = b_raw[W-1:0];
	assign na   = a[W-1];
	assign nb   = b[W-1];
	assign na_v = W'(0) - a;
	assign nb_v = W'(0) - b;
	assign big  = b_raw >= 64'(W);
	assign sh   = b_raw[SW-1:0];

	always_comb begin
		simple = '0;
		case (func)
			FN_AND: simple = a & b;
			FN_OR:  simple = a | b;
			FN_XOR: simple = a ^ b;
			FN_NOT: simple = ~a;
			FN_SHL: simple = big ? '0 : (a << sh);
			FN_SHR: simple = big ? '0 : (a >> sh);
			FN_SAR: simple = big ? {W{na}} : W'($signed(a) >>> sh);
			FN_ADD: simple = a + b;
			FN_SUB: simple = a - b;
			FN_NEG: simple = na_v;
			FN_EQ:  simple = W'(a == b);
			FN_LT:  simple = W'($signed(a) < $signed(b));
			FN_LE:  simple = W'($signed(a) <= $signed(b));
			default: simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1.vld   <= in_vld;
			ctl_s1.func  <= func;
			ctl_s1.qneg  <= na ^ nb;
			ctl_s1.rneg  <= na;
			ctl_s1.bzero <= (b == '0);
			ctl_s1.azero <= (a == '0);
			ctl_s2       <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alt_s1       <= simple;
			ma_s1        <= na ? na_v : a;
			mb_s1        <= (b == '0) ? W'(1) : (nb ? nb_v : b);
			p0_s1        <= (2*H)'(a[H-1:0]) * (2*H)'(b[H-1:0]);
			p1_s1        <= L2'(a[H-1:0] * b[W-1:H]);
			p2_s1        <= L2'(a[W-1:H] * b[H-1:0]);

			alt_s2       <= (ctl_s1.func == FN_MUL) ? mul_sum : alt_s1;
			ma_s2        <= ma_s1;
			mb_s2        <= mb_s1;
		end
	end

	assign mul_sum = W'(p0_s1) + {p1_s1 + p2_s1, {H{1'b0}}};

endmodule

[design/i64alu_div.sv]
// ----------------------------------------------------------------------------
// i64alu_div: pipelined restoring divider
// One quotient bit per stage over W stages; control and the merged result
// of the other operations ride along.
// ----------------------------------------------------------------------------
module i64alu_div import i64alu_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  ctl_t         ctl_in,
	input  logic [W-1:0] alt_in,
	input  logic [W-1:0] ma,
	input  logic [W-1:0] mb,
	output ctl_t         ctl_out,
	output logic [W-1:0] alt_out,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	ctl_t         ctl_s [W+1];
	logic [W-1:0] alt_s [W+1];
	logic [W-1:0] num_s [W+1];
	logic [W-1:0] rem_s [W+1];
	logic [W-1:0] den_s [W+1];

	assign ctl_s[0] = ctl_in;
	assign alt_s[0] = alt_in;
	assign num_s[0] = ma;
	assign rem_s[0] = '0;
	assign den_s[0] = mb;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0] t, d;
		logic       ge;

		assign t  = {rem_s[i], num_s[i][W-1]};
		assign d  = t - {1'b0, den_s[i]};
		assign ge = !d[W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (adv) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				alt_s[i+1]       <= alt_s[i];
				num_s[i+1]       <= {num_s[i][W-2:0], ge};
				rem_s[i+1]       <= ge ? d[W-1:0] : t[W-1:0];
				den_s[i+1]       <= den_s[i];
			end
		end
	end

	assign ctl_out = ctl_s[W];
	assign alt_out = alt_s[W];
	assign quo     = num_s[W];
	assign rem     = rem_s[W];

endmodule

[design/i64alu_post.sv]
// ----------------------------------------------------------------------------
// i64alu_post: result select and output register
// Applies signs and the divide-by-zero rules, then registers the result
// together with its 53-bit range flag.
// ----------------------------------------------------------------------------
module i64alu_post import i64alu_pkg::*; #(
	parameter int W         = DATA_WIDTH_DEF,
	parameter int SAFE_BITS = SAFE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  ctl_t               ctl,
	input  logic [W-1:0]       alt,
	input  logic [W-1:0]       quo,
	input  logic [W-1:0]       rem,
	output logic               vld_s2,
	output logic signed [63:0] res_s2,
	output logic               fits_s2
);

	localparam logic [W-1:0]       MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]       MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [64:0] LIM  = 65'((65'd1 << SAFE_BITS) - 65'd1);

	logic [W-1:0]       sel;
	logic               vld_s1;
	logic [W-1:0]       res_s1;
	logic signed [64:0] rx;

	always_comb begin
		case (ctl.func)
			FN_DIV: begin
				if (ctl.bzero)
					sel = ctl.azero ? W'(1) : (ctl.rneg ? MINV : MAXV);
				else
					sel = ctl.qneg ? (W'(0) - quo) : quo;
			end
			FN_MOD: sel = ctl.rneg ? (W'(0) - rem) : rem;
			default: sel = alt;
		endcase
	end

	assign rx = 65'($signed(res_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1  <= sel;
			res_s2  <= 64'($signed(res_s1));
			fits_s2 <= (rx <= LIM) && (rx >= -LIM);
		end
	end

endmodule
